// ===== src/cbf_pkg.sv =====
// Shared types and character constants for the comment blanking filter.
package cbf_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_BLANK  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [7:0] {
    MODE_NORMAL     = 8'b0000_0001,
    MODE_QUOTE      = 8'b0000_0010,
    MODE_QUOTE_ESC  = 8'b0000_0100,
    MODE_LINE       = 8'b0000_1000,
    MODE_SLASH_BLK  = 8'b0001_0000,
    MODE_SLASH_STAR = 8'b0010_0000,
    MODE_PAREN_BLK  = 8'b0100_0000,
    MODE_PAREN_STAR = 8'b1000_0000
  } scan_mode_t;

endpackage

// ===== src/comment_blanking_filter_top.sv =====
// Comment blanking filter: streams text and replaces comments with spaces.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------
//  input   | in        | in_valid / in_ready | text_byte, final_byte
//  output  | out       | out_valid/out_ready | out_byte, out_final
//
// One byte per cycle is taken while in_ready; each gives zero, one or two output
// words in the next cycle, and over a text the counts match one to one.
// The scanner state updates at the input edge and the words go into a
// four-entry output queue; input is taken while at least two entries are free.
// A stalled output fills the queue and then holds off input, nothing is lost.
// Reset (synchronous) empties the queue and returns the scanner to line start.
module comment_blanking_filter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_final
);
  import cbf_pkg::*;

  scan_mode_t scan_mode, scan_mode_next;
  logic       quote_is_double, quote_is_double_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic       line_start, line_start_next;

  logic [7:0]     q_byte [QDEPTH];
  logic           q_fin  [QDEPTH];
  logic [7:0]     q_byte_next [QDEPTH];
  logic           q_fin_next  [QDEPTH];
  logic [QCW-1:0] count, count_next, count_pop;

  logic       in_accept, out_pop;
  logic [1:0] n_res;
  logic [7:0] r0, r1;
  logic       f0, f1;

  // Handling of the current byte as normal text with nothing held.
  logic       norm_emit, norm_hold, norm_qd;
  logic [7:0] norm_byte;
  scan_mode_t norm_mode;

  assign in_ready  = (count <= QCW'(QDEPTH - 2));
  assign in_accept = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_pop   = out_valid && out_ready;
  assign out_byte  = q_byte[0];
  assign out_final = q_fin[0];

  always_comb begin
    norm_emit = 1'b1;
    norm_hold = 1'b0;
    norm_qd   = quote_is_double;
    norm_byte = text_byte;
    norm_mode = MODE_NORMAL;
    if (line_start && text_byte == CH_HASH) begin
      norm_mode = MODE_LINE;
      norm_byte = CH_BLANK;
    end else if ((text_byte == CH_SLASH || text_byte == CH_LPAREN) && !final_byte) begin
      norm_emit = 1'b0;
      norm_hold = 1'b1;
    end else if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
      norm_mode = MODE_QUOTE;
      norm_qd   = (text_byte == CH_DQUOTE);
    end
  end

  always_comb begin
    scan_mode_next       = scan_mode;
    quote_is_double_next = quote_is_double;
    held_byte_next       = held_byte;
    held_valid_next      = held_valid;
    n_res = 2'd0;
    r0    = CH_BLANK;
    r1    = CH_BLANK;

    if (held_valid) begin
      held_valid_next = 1'b0;
      if (held_byte == CH_SLASH && text_byte == CH_SLASH) begin
        scan_mode_next = MODE_LINE;
        n_res = 2'd2;
      end else if (held_byte == CH_SLASH && text_byte == CH_STAR) begin
        scan_mode_next = MODE_SLASH_BLK;
        n_res = 2'd2;
      end else if (held_byte == CH_LPAREN && text_byte == CH_STAR) begin
        scan_mode_next = MODE_PAREN_BLK;
        n_res = 2'd2;
      end else begin
        // The held byte opened nothing: send it, then treat this byte as text.
        r0 = held_byte;
        r1 = norm_byte;
        n_res = norm_emit ? 2'd2 : 2'd1;
        scan_mode_next       = norm_mode;
        quote_is_double_next = norm_qd;
        held_valid_next      = norm_hold;
        if (norm_hold) begin
          held_byte_next = text_byte;
        end
      end
    end else begin
      n_res = 2'd1;
      r0    = CH_BLANK;
      case (scan_mode)
        MODE_QUOTE: begin
          r0 = text_byte;
          if (text_byte == CH_BSLASH) begin
            scan_mode_next = MODE_QUOTE_ESC;
          end else if (text_byte == (quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
            scan_mode_next = MODE_NORMAL;
          end
        end
        MODE_QUOTE_ESC: begin
          r0 = text_byte;
          scan_mode_next = MODE_QUOTE;
        end
        MODE_LINE: begin
          if (text_byte == CH_LF) begin
            r0 = text_byte;
            scan_mode_next = MODE_NORMAL;
          end
        end
        MODE_SLASH_BLK, MODE_SLASH_STAR: begin
          if (scan_mode == MODE_SLASH_STAR && text_byte == CH_SLASH) begin
            scan_mode_next = MODE_NORMAL;
          end else begin
            scan_mode_next = (text_byte == CH_STAR) ? MODE_SLASH_STAR : MODE_SLASH_BLK;
          end
        end
        MODE_PAREN_BLK, MODE_PAREN_STAR: begin
          if (scan_mode == MODE_PAREN_STAR && text_byte == CH_RPAREN) begin
            scan_mode_next = MODE_NORMAL;
          end else begin
            scan_mode_next = (text_byte == CH_STAR) ? MODE_PAREN_STAR : MODE_PAREN_BLK;
          end
        end
        default: begin
          r0    = norm_byte;
          n_res = norm_emit ? 2'd1 : 2'd0;
          scan_mode_next       = norm_mode;
          quote_is_double_next = norm_qd;
          held_valid_next      = norm_hold;
          if (norm_hold) begin
            held_byte_next = text_byte;
          end
        end
      endcase
    end

    line_start_next = (text_byte == CH_LF);
    f0 = final_byte && (n_res == 2'd1);
    f1 = final_byte;

    // The last byte of a text ends any open comment or string.
    if (final_byte) begin
      scan_mode_next       = MODE_NORMAL;
      quote_is_double_next = 1'b0;
      held_byte_next       = '0;
      held_valid_next      = 1'b0;
      line_start_next      = 1'b1;
    end
  end

  // Output queue: head at entry 0, shifts on pop, new words appended behind.
  always_comb begin
    count_pop = count - QCW'(out_pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (out_pop && i < QDEPTH - 1) begin
        q_byte_next[i] = q_byte[i + 1];
        q_fin_next[i]  = q_fin[i + 1];
      end else begin
        q_byte_next[i] = q_byte[i];
        q_fin_next[i]  = q_fin[i];
      end
      if (in_accept && n_res != 2'd0 && QCW'(i) == count_pop) begin
        q_byte_next[i] = r0;
        q_fin_next[i]  = f0;
      end
      if (in_accept && n_res == 2'd2 && QCW'(i) == count_pop + QCW'(1)) begin
        q_byte_next[i] = r1;
        q_fin_next[i]  = f1;
      end
    end
    count_next = in_accept ? count_pop + QCW'(n_res) : count_pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= MODE_NORMAL;
      quote_is_double <= 1'b0;
      held_byte       <= '0;
      held_valid      <= 1'b0;
      line_start      <= 1'b1;
      count           <= '0;
    end else begin
      if (in_accept) begin
        scan_mode       <= scan_mode_next;
        quote_is_double <= quote_is_double_next;
        held_byte       <= held_byte_next;
        held_valid      <= held_valid_next;
        line_start      <= line_start_next;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_byte[i] <= q_byte_next[i];
      q_fin[i]  <= q_fin_next[i];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("output queue count out of range");

  a_held_normal: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> scan_mode == MODE_NORMAL)
    else $error("byte held outside normal text");

  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    in_accept && final_byte |=> !held_valid && line_start && scan_mode == MODE_NORMAL)
    else $error("scanner not back at line start after last byte");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    out_pop && !in_accept |=> count == $past(count) - QCW'(1))
    else $error("queue count wrong after pop");

endmodule
